// ----- hdl/spn_pkg.sv -----
// ----------------------------------------------------------------------------
// spn_pkg
// shared types, codes and tables of the speckle probe nulling estimator
// ----------------------------------------------------------------------------
package spn_pkg;

   // operation codes carried in the mode field
   localparam logic [1:0] MODE_PLAIN     = 2'd0;
   localparam logic [1:0] MODE_PROBE     = 2'd1;
   localparam logic [1:0] MODE_PROBE_REQ = 2'd2;
   localparam logic [1:0] MODE_END_PROBE = 2'd3;

   // register indexes on the csr port
   localparam int unsigned CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_CAL_FACTOR    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_NULLING_GAIN  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SNR_THRESHOLD = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_WAVE_X        = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_WAVE_Y        = 3'd4;

   localparam int unsigned NUM_PHASES   = 4;
   localparam int unsigned CORDIC_STEPS = 20;
   localparam logic [23:0] TURN_HALF    = 24'h800000;
   localparam logic [23:0] PHASE_ROUND  = 24'd128;
   localparam logic [45:0] RAW_MAX      = 46'h3FFF_FFFF_FFFF;
   localparam logic [31:0] U32_MAX      = 32'hFFFF_FFFF;

   typedef struct packed {
      logic [1:0]  mode;
      logic [1:0]  phase_index;
      logic [23:0] intensity;
      logic [31:0] variance;
      logic [15:0] iteration_count;
   } spn_req_type;

   typedef struct packed {
      logic [31:0]        amplitude;
      logic [15:0]        phase;
      logic               is_nulling;
      logic               snr_met;
      logic signed [15:0] out_wave_x;
      logic signed [15:0] out_wave_y;
   } spn_rsp_type;

   // launch pulses into the serial arithmetic unit
   typedef struct packed {
      logic mul_go;
      logic div_go;
      logic sqrt_go;
   } spn_ctl_type;

   // completion pulses out of the serial arithmetic unit
   typedef struct packed {
      logic mul_done;
      logic div_done;
      logic sqrt_done;
   } spn_sts_type;

   // atan(2^-i) in 2^-24 turn units
   function automatic logic [23:0] atan_turn(input logic [4:0] i);
      logic [23:0] v;
      case (i)
         5'd0:  v = 24'd2097152;
         5'd1:  v = 24'd1238021;
         5'd2:  v = 24'd654136;
         5'd3:  v = 24'd332050;
         5'd4:  v = 24'd166669;
         5'd5:  v = 24'd83416;
         5'd6:  v = 24'd41718;
         5'd7:  v = 24'd20860;
         5'd8:  v = 24'd10430;
         5'd9:  v = 24'd5215;
         5'd10: v = 24'd2608;
         5'd11: v = 24'd1304;
         5'd12: v = 24'd652;
         5'd13: v = 24'd326;
         5'd14: v = 24'd163;
         5'd15: v = 24'd81;
         5'd16: v = 24'd41;
         5'd17: v = 24'd20;
         5'd18: v = 24'd10;
         5'd19: v = 24'd5;
         default: v = 24'd0;
      endcase
      return v;
   endfunction

endpackage

// ----- hdl/speckle_probe_nulling_estimator.sv -----
// ----------------------------------------------------------------------------
// speckle_probe_nulling_estimator
// four-phase probe speckle field estimator and nulling command generator
// ----------------------------------------------------------------------------
// A word is taken when start is high and busy is low. Probe measurements and
// probe requests leave busy low, and a probe request answers with rsp_strobe
// on the next cycle. A plain measurement keeps busy high through a square
// root, a multiply by the calibration, a multiply of the old amplitude by the
// iteration count and one divide. An end of probe runs the normalize shift,
// 20 cordic steps, then two square roots, up to five multiplies and up to
// three divides in sequence. The arithmetic runs through one shared serial
// arithmetic unit that retires one bit per cycle. Results appear for exactly
// one cycle with rsp_strobe and cannot be held off. Config writes are always
// ready and belong in idle time.
// ----------------------------------------------------------------------------
module speckle_probe_nulling_estimator
   import spn_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  spn_req_type           req_data,
   output logic                  rsp_strobe,
   output spn_rsp_type           rsp_data,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [31:0]           csr_wdata
);

   typedef enum logic [4:0] {
      ST_IDLE, ST_M0_ROOT, ST_M0_CAL, ST_M0_OLD, ST_M0_DIV,
      ST_NORM, ST_CORD, ST_SQ_RE, ST_SQ_IM, ST_MAG, ST_VSUM, ST_SIG,
      ST_SNR, ST_CAL2, ST_ADIV, ST_AMUL, ST_RDIV, ST_GMUL
   } state_type;

   state_type state_ff;

   // configuration
   logic [31:0]        cal_ff;
   logic [17:0]        gain_ff;
   logic [31:0]        thr_ff;
   logic signed [15:0] wave_x_ff;
   logic signed [15:0] wave_y_ff;

   // estimator state
   logic [31:0] probe_amp_ff;
   logic [39:0] isum_ff [NUM_PHASES];
   logic [47:0] vsum_ff [NUM_PHASES];

   // current word and scratch
   spn_req_type        item_ff;
   logic [63:0]        t_ff;
   logic [40:0]        ar_ff;
   logic [40:0]        ai_ff;
   logic               neg_re_ff;
   logic               neg_im_ff;
   logic [3:0]         k_ff;
   logic [41:0]        m_ff;
   logic signed [34:0] cx_ff;
   logic signed [34:0] cy_ff;
   logic [23:0]        z_ff;
   logic [4:0]         step_ff;
   logic [49:0]        vt_ff;
   logic [1:0]         vidx_ff;
   logic               met_ff;

   // arithmetic unit hookup
   spn_ctl_type  ctl_ff;
   spn_sts_type  sts;
   logic [63:0]  mul_a_ff;
   logic [63:0]  mul_b_ff;
   logic [127:0] mul_p;
   logic [63:0]  div_n_ff;
   logic [33:0]  div_d_ff;
   logic [63:0]  div_q;
   logic [63:0]  sqrt_v_ff;
   logic [31:0]  sqrt_r;

   spn_rsp_type rsp_ff;
   logic        rsp_strobe_ff;

   spn_arith u_arith (
      .clock  (clock),
      .reset  (reset),
      .ctl    (ctl_ff),
      .sts    (sts),
      .mul_a  (mul_a_ff),
      .mul_b  (mul_b_ff),
      .mul_p  (mul_p),
      .div_n  (div_n_ff),
      .div_d  (div_d_ff),
      .div_q  (div_q),
      .sqrt_v (sqrt_v_ff),
      .sqrt_r (sqrt_r)
   );

   logic               accept_w;
   logic [1:0]         slot_w;
   logic [40:0]        isum_add_w;
   logic [48:0]        vsum_add_w;
   logic [40:0]        dre_w;
   logic [40:0]        dim_w;
   logic [40:0]        are_w;
   logic [40:0]        aim_w;
   logic               negx_w;
   logic signed [34:0] y0_w;
   logic signed [34:0] dx_w;
   logic signed [34:0] dy_w;
   logic [23:0]        ph_w;
   logic [31:0]        snr_w;
   logic [45:0]        raw_w;
   logic [47:0]        gp_w;
   spn_rsp_type        nul_w;
   spn_rsp_type        fin_w;

   assign accept_w = start && (state_ff == ST_IDLE);
   assign slot_w   = req_data.phase_index;

   // saturating per-phase accumulation
   assign isum_add_w = {1'b0, isum_ff[slot_w]} + {17'd0, req_data.intensity};
   assign vsum_add_w = {1'b0, vsum_ff[slot_w]} + {17'd0, req_data.variance};

   // differential field from opposite probe phases
   assign dre_w = {1'b0, isum_ff[0]} - {1'b0, isum_ff[2]};
   assign dim_w = {1'b0, isum_ff[1]} - {1'b0, isum_ff[3]};
   assign are_w = dre_w[40] ? -dre_w : dre_w;
   assign aim_w = dim_w[40] ? -dim_w : dim_w;

   // cordic start vector folded into the right half plane
   assign negx_w = neg_re_ff && (ar_ff != 41'd0);
   assign y0_w   = (neg_im_ff ^ negx_w) ? -$signed({4'd0, ai_ff[30:0]})
                                        :  $signed({4'd0, ai_ff[30:0]});
   assign dx_w   = cy_ff >>> step_ff;
   assign dy_w   = cx_ff >>> step_ff;

   // half a turn offset, rounded to 16 bits
   assign ph_w = z_ff + TURN_HALF + PHASE_ROUND;

   assign snr_w = (div_q[63:32] != 32'd0) ? U32_MAX : div_q[31:0];
   assign raw_w = (div_q > {18'd0, RAW_MAX}) ? RAW_MAX : div_q[45:0];
   assign gp_w  = mul_p[63:16];

   always_comb begin
      nul_w            = '0;
      nul_w.phase      = ph_w[23:8];
      nul_w.is_nulling = 1'b1;
      nul_w.out_wave_x = wave_x_ff;
      nul_w.out_wave_y = wave_y_ff;
   end

   // gained nulling command, saturated to 32 bits
   always_comb begin
      fin_w           = nul_w;
      fin_w.amplitude = (gp_w[47:32] != 16'd0) ? U32_MAX : gp_w[31:0];
      fin_w.snr_met   = met_ff;
   end

   always_ff @(posedge clock) begin
      ctl_ff        <= '0;
      rsp_strobe_ff <= 1'b0;

      if (csr_valid) begin
         unique case (csr_index)
            CSR_CAL_FACTOR:    cal_ff    <= csr_wdata;
            CSR_NULLING_GAIN:  gain_ff   <= csr_wdata[17:0];
            CSR_SNR_THRESHOLD: thr_ff    <= csr_wdata;
            CSR_WAVE_X:        wave_x_ff <= signed'(csr_wdata[15:0]);
            CSR_WAVE_Y:        wave_y_ff <= signed'(csr_wdata[15:0]);
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept_w) begin
               item_ff <= req_data;
               unique case (req_data.mode)
                  MODE_PLAIN: begin
                     // root of intensity in Q16.16
                     sqrt_v_ff      <= {8'd0, req_data.intensity, 32'd0};
                     ctl_ff.sqrt_go <= 1'b1;
                     state_ff       <= ST_M0_ROOT;
                  end
                  MODE_PROBE: begin
                     isum_ff[slot_w] <= isum_add_w[40] ? '1 : isum_add_w[39:0];
                     vsum_ff[slot_w] <= vsum_add_w[48] ? '1 : vsum_add_w[47:0];
                  end
                  MODE_PROBE_REQ: begin
                     rsp_ff.amplitude  <= probe_amp_ff;
                     rsp_ff.phase      <= {slot_w, 14'd0};
                     rsp_ff.is_nulling <= 1'b0;
                     rsp_ff.snr_met    <= 1'b0;
                     rsp_ff.out_wave_x <= wave_x_ff;
                     rsp_ff.out_wave_y <= wave_y_ff;
                     rsp_strobe_ff     <= 1'b1;
                  end
                  default: begin
                     ar_ff     <= are_w;
                     ai_ff     <= aim_w;
                     neg_re_ff <= dre_w[40];
                     neg_im_ff <= dim_w[40];
                     k_ff      <= '0;
                     state_ff  <= ST_NORM;
                  end
               endcase
            end
         end

         // plain measurement: weighted running mean of root intensity
         ST_M0_ROOT: if (sts.sqrt_done) begin
            mul_a_ff      <= {32'd0, sqrt_r};
            mul_b_ff      <= {32'd0, cal_ff};
            ctl_ff.mul_go <= 1'b1;
            state_ff      <= ST_M0_CAL;
         end
         ST_M0_CAL: if (sts.mul_done) begin
            t_ff          <= {16'd0, mul_p[63:16]};
            mul_a_ff      <= {32'd0, probe_amp_ff};
            mul_b_ff      <= {48'd0, item_ff.iteration_count};
            ctl_ff.mul_go <= 1'b1;
            state_ff      <= ST_M0_OLD;
         end
         ST_M0_OLD: if (sts.mul_done) begin
            div_n_ff      <= t_ff + mul_p[63:0];
            div_d_ff      <= 34'({1'b0, item_ff.iteration_count} + 17'd1);
            ctl_ff.div_go <= 1'b1;
            state_ff      <= ST_M0_DIV;
         end
         ST_M0_DIV: if (sts.div_done) begin
            probe_amp_ff <= snr_w;
            state_ff     <= ST_IDLE;
         end

         // end of probe: halve both parts until they fit 31 bits
         ST_NORM: begin
            if ((ar_ff[40:31] | ai_ff[40:31]) != 10'd0) begin
               ar_ff <= {1'b0, ar_ff[40:1]};
               ai_ff <= {1'b0, ai_ff[40:1]};
               k_ff  <= k_ff + 4'd1;
            end else if (ar_ff == 41'd0 && ai_ff == 41'd0) begin
               // zero field: angle zero, skip the rotation
               z_ff          <= '0;
               mul_a_ff      <= '0;
               mul_b_ff      <= '0;
               ctl_ff.mul_go <= 1'b1;
               state_ff      <= ST_SQ_RE;
            end else begin
               cx_ff    <= $signed({4'd0, ar_ff[30:0]});
               cy_ff    <= y0_w;
               z_ff     <= negx_w ? TURN_HALF : 24'd0;
               step_ff  <= '0;
               state_ff <= ST_CORD;
            end
         end
         ST_CORD: begin
            if (cy_ff > 35'sd0) begin
               cx_ff <= cx_ff + dx_w;
               cy_ff <= cy_ff - dy_w;
               z_ff  <= z_ff + atan_turn(step_ff);
            end else begin
               cx_ff <= cx_ff - dx_w;
               cy_ff <= cy_ff + dy_w;
               z_ff  <= z_ff - atan_turn(step_ff);
            end
            step_ff <= step_ff + 5'd1;
            if (step_ff == 5'(CORDIC_STEPS - 1)) begin
               mul_a_ff      <= {33'd0, ar_ff[30:0]};
               mul_b_ff      <= {33'd0, ar_ff[30:0]};
               ctl_ff.mul_go <= 1'b1;
               state_ff      <= ST_SQ_RE;
            end
         end
         ST_SQ_RE: if (sts.mul_done) begin
            t_ff          <= mul_p[63:0];
            mul_a_ff      <= {33'd0, ai_ff[30:0]};
            mul_b_ff      <= {33'd0, ai_ff[30:0]};
            ctl_ff.mul_go <= 1'b1;
            state_ff      <= ST_SQ_IM;
         end
         ST_SQ_IM: if (sts.mul_done) begin
            sqrt_v_ff      <= t_ff + mul_p[63:0];
            ctl_ff.sqrt_go <= 1'b1;
            state_ff       <= ST_MAG;
         end
         ST_MAG: if (sts.sqrt_done) begin
            m_ff     <= 42'(sqrt_r) << k_ff;
            vt_ff    <= '0;
            vidx_ff  <= '0;
            state_ff <= ST_VSUM;
         end
         // total variance, one phase per cycle
         ST_VSUM: begin
            vt_ff   <= vt_ff + {2'd0, vsum_ff[vidx_ff]};
            vidx_ff <= vidx_ff + 2'd1;
            if (vidx_ff == 2'(NUM_PHASES - 1)) begin
               sqrt_v_ff      <= {7'd0, vt_ff + {2'd0, vsum_ff[vidx_ff]}, 7'd0};
               ctl_ff.sqrt_go <= 1'b1;
               state_ff       <= ST_SIG;
            end
         end
         ST_SIG: if (sts.sqrt_done) begin
            if (probe_amp_ff == 32'd0 || item_ff.iteration_count == 16'd0
                || sqrt_r == 32'd0) begin
               rsp_ff        <= nul_w;
               rsp_strobe_ff <= 1'b1;
               state_ff      <= ST_IDLE;
            end else begin
               div_n_ff      <= {2'd0, m_ff, 20'd0};
               div_d_ff      <= {2'd0, sqrt_r};
               ctl_ff.div_go <= 1'b1;
               state_ff      <= ST_SNR;
            end
         end
         ST_SNR: if (sts.div_done) begin
            if (snr_w >= thr_ff) begin
               met_ff        <= 1'b1;
               mul_a_ff      <= {32'd0, cal_ff};
               mul_b_ff      <= {32'd0, cal_ff};
               ctl_ff.mul_go <= 1'b1;
               state_ff      <= ST_CAL2;
            end else begin
               rsp_ff        <= nul_w;
               rsp_strobe_ff <= 1'b1;
               state_ff      <= ST_IDLE;
            end
         end
         // squared calibration over four times the probe amplitude
         ST_CAL2: if (sts.mul_done) begin
            div_n_ff      <= mul_p[63:0];
            div_d_ff      <= {probe_amp_ff, 2'b00};
            ctl_ff.div_go <= 1'b1;
            state_ff      <= ST_ADIV;
         end
         ST_ADIV: if (sts.div_done) begin
            mul_a_ff      <= div_q;
            mul_b_ff      <= {22'd0, m_ff};
            ctl_ff.mul_go <= 1'b1;
            state_ff      <= ST_AMUL;
         end
         ST_AMUL: if (sts.mul_done) begin
            if (mul_p[127:64] != 64'd0) begin
               // product past 64 bits saturates the raw amplitude
               mul_a_ff      <= {18'd0, RAW_MAX};
               mul_b_ff      <= {46'd0, gain_ff};
               ctl_ff.mul_go <= 1'b1;
               state_ff      <= ST_GMUL;
            end else begin
               div_n_ff      <= mul_p[63:0];
               div_d_ff      <= {18'd0, item_ff.iteration_count};
               ctl_ff.div_go <= 1'b1;
               state_ff      <= ST_RDIV;
            end
         end
         ST_RDIV: if (sts.div_done) begin
            mul_a_ff      <= {18'd0, raw_w};
            mul_b_ff      <= {46'd0, gain_ff};
            ctl_ff.mul_go <= 1'b1;
            state_ff      <= ST_GMUL;
         end
         ST_GMUL: if (sts.mul_done) begin
            rsp_ff        <= fin_w;
            rsp_strobe_ff <= 1'b1;
            state_ff      <= ST_IDLE;
         end
         default: state_ff <= ST_IDLE;
      endcase

      if (reset) begin
         state_ff      <= ST_IDLE;
         ctl_ff        <= '0;
         rsp_strobe_ff <= 1'b0;
         met_ff        <= 1'b0;
         cal_ff        <= 32'd65536;
         gain_ff       <= 18'd65536;
         thr_ff        <= 32'd196608;
         wave_x_ff     <= '0;
         wave_y_ff     <= '0;
         probe_amp_ff  <= '0;
         for (int i = 0; i < NUM_PHASES; i++) begin
            isum_ff[i] <= '0;
            vsum_ff[i] <= '0;
         end
      end
   end

   assign busy       = (state_ff != ST_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

   // a probe request answers on the very next cycle
   a_probe_req_answer : assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_data.mode == MODE_PROBE_REQ) |=>
         (rsp_strobe && !rsp_data.is_nulling))
      else $error("probe request not answered");

   // a probe command never reports snr met
   a_probe_no_snr : assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_data.is_nulling) |-> !rsp_data.snr_met)
      else $error("probe command with snr met");

   // below threshold or zero divisor the nulling amplitude is zero
   a_null_amp_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.is_nulling && !rsp_data.snr_met) |->
         (rsp_data.amplitude == 32'd0))
      else $error("nonzero amplitude without snr");

   // cordic never runs past its last step
   a_cordic_bound : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CORD) |-> (step_ff < 5'(CORDIC_STEPS)))
      else $error("cordic step out of range");

endmodule

// ----- hdl/spn_arith.sv -----
// ----------------------------------------------------------------------------
// spn_arith
// bit-serial multiplier, restoring divider and square root, one bit a cycle
// ----------------------------------------------------------------------------
module spn_arith
   import spn_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  spn_ctl_type   ctl,
   output spn_sts_type   sts,
   input  logic [63:0]   mul_a,
   input  logic [63:0]   mul_b,
   output logic [127:0]  mul_p,
   input  logic [63:0]   div_n,
   input  logic [33:0]   div_d,
   output logic [63:0]   div_q,
   input  logic [63:0]   sqrt_v,
   output logic [31:0]   sqrt_r
);

   // multiplier: shift-add, finishes when the multiplier runs out of ones
   logic [127:0] mcand_ff;
   logic [127:0] acc_ff;
   logic [63:0]  mplier_ff;
   logic         mul_busy_ff;
   logic         mul_done_ff;

   always_ff @(posedge clock) begin
      mul_done_ff <= 1'b0;
      if (ctl.mul_go) begin
         mcand_ff    <= {64'd0, mul_a};
         mplier_ff   <= mul_b;
         acc_ff      <= '0;
         mul_busy_ff <= 1'b1;
      end else if (mul_busy_ff) begin
         if (mplier_ff == 64'd0) begin
            mul_busy_ff <= 1'b0;
            mul_done_ff <= 1'b1;
         end else begin
            if (mplier_ff[0]) acc_ff <= acc_ff + mcand_ff;
            mcand_ff  <= {mcand_ff[126:0], 1'b0};
            mplier_ff <= {1'b0, mplier_ff[63:1]};
         end
      end
      if (reset) begin
         mul_busy_ff <= 1'b0;
         mul_done_ff <= 1'b0;
      end
   end

   // divider: one quotient bit a cycle, msb first
   logic [63:0] quo_ff;
   logic [33:0] rem_ff;
   logic [33:0] dvs_ff;
   logic [5:0]  div_cnt_ff;
   logic        div_busy_ff;
   logic        div_done_ff;
   logic [34:0] div_t_w;
   logic        div_ge_w;

   assign div_t_w  = {rem_ff, quo_ff[63]};
   assign div_ge_w = div_t_w >= {1'b0, dvs_ff};

   always_ff @(posedge clock) begin
      div_done_ff <= 1'b0;
      if (ctl.div_go) begin
         quo_ff      <= div_n;
         rem_ff      <= '0;
         dvs_ff      <= div_d;
         div_cnt_ff  <= '0;
         div_busy_ff <= 1'b1;
      end else if (div_busy_ff) begin
         rem_ff     <= div_ge_w ? 34'(div_t_w - {1'b0, dvs_ff}) : div_t_w[33:0];
         quo_ff     <= {quo_ff[62:0], div_ge_w};
         div_cnt_ff <= div_cnt_ff + 6'd1;
         if (div_cnt_ff == 6'd63) begin
            div_busy_ff <= 1'b0;
            div_done_ff <= 1'b1;
         end
      end
      if (reset) begin
         div_busy_ff <= 1'b0;
         div_done_ff <= 1'b0;
         div_cnt_ff  <= '0;
      end
   end

   // square root: two radicand bits a cycle
   logic [63:0] rad_ff;
   logic [33:0] srem_ff;
   logic [31:0] root_ff;
   logic [4:0]  sq_cnt_ff;
   logic        sq_busy_ff;
   logic        sq_done_ff;
   logic [35:0] sq_t_w;
   logic [35:0] sq_trial_w;
   logic        sq_ge_w;

   assign sq_t_w     = {srem_ff, rad_ff[63:62]};
   assign sq_trial_w = {2'b00, root_ff, 2'b01};
   assign sq_ge_w    = sq_t_w >= sq_trial_w;

   always_ff @(posedge clock) begin
      sq_done_ff <= 1'b0;
      if (ctl.sqrt_go) begin
         rad_ff     <= sqrt_v;
         srem_ff    <= '0;
         root_ff    <= '0;
         sq_cnt_ff  <= '0;
         sq_busy_ff <= 1'b1;
      end else if (sq_busy_ff) begin
         srem_ff   <= sq_ge_w ? 34'(sq_t_w - sq_trial_w) : sq_t_w[33:0];
         root_ff   <= {root_ff[30:0], sq_ge_w};
         rad_ff    <= {rad_ff[61:0], 2'b00};
         sq_cnt_ff <= sq_cnt_ff + 5'd1;
         if (sq_cnt_ff == 5'd31) begin
            sq_busy_ff <= 1'b0;
            sq_done_ff <= 1'b1;
         end
      end
      if (reset) begin
         sq_busy_ff <= 1'b0;
         sq_done_ff <= 1'b0;
         sq_cnt_ff  <= '0;
      end
   end

   assign mul_p         = acc_ff;
   assign div_q         = quo_ff;
   assign sqrt_r        = root_ff;
   assign sts.mul_done  = mul_done_ff;
   assign sts.div_done  = div_done_ff;
   assign sts.sqrt_done = sq_done_ff;

endmodule
